// ----- src/mlfsr_pkg.sv -----
// Shared types and constants for the maximal LFSR polynomial test block.
package mlfsr_pkg;

   localparam int DATA_W   = 24;   // polynomial, seed and result field width
   localparam int CFG_W    = 5;    // width and weight register width
   localparam int CSR_IDX_W = 2;
   localparam int RSP_W    = 56;   // 50 payload bits padded to whole bytes
   localparam int RSP_PAD  = RSP_W - (DATA_W + 1 + DATA_W + 1);

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEED   = 2'd2;

   localparam logic [CFG_W-1:0]  WIDTH_RST  = 5'd24;
   localparam logic [CFG_W-1:0]  WEIGHT_RST = 5'd4;
   localparam logic [DATA_W-1:0] SEED_RST   = 24'd7;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_COUNT = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_DONE  = 4'b1000
   } fsm_state_type;

   // status from the stepping engine
   typedef struct packed {
      logic done;    // search finished this cycle
      logic found;   // seed came back within the bound
   } eng_sts_type;

endpackage

// ----- src/mlfsr_engine.sv -----
// Galois LFSR stepping engine: one step per cycle until the seed recurs or the bound.
module mlfsr_engine
   import mlfsr_pkg::*;
#(
   parameter int MAX_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DATA_W-1:0]    poly,
   input  logic [DATA_W-1:0]    seed,
   input  logic [MAX_WIDTH-1:0] limit,   // 2^width - 1, last step index
   output eng_sts_type          sts,
   output logic [MAX_WIDTH-1:0] steps
);

   logic                 run_ff,  run_in;
   logic [DATA_W-1:0]    lfsr_ff, lfsr_in;
   logic [MAX_WIDTH-1:0] cnt_ff,  cnt_in;
   logic                 hit;
   logic                 at_end;
   logic [DATA_W-1:0]    lfsr_next;

   assign hit       = (cnt_ff != '0) && (lfsr_ff == seed);
   assign at_end    = (cnt_ff == limit);
   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ poly) : (lfsr_ff >> 1);

   assign sts.done  = run_ff && (hit || at_end);
   assign sts.found = run_ff && hit;
   assign steps     = cnt_ff;

   always_comb begin
      run_in  = run_ff;
      lfsr_in = lfsr_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         run_in  = 1'b1;
         lfsr_in = seed;
         cnt_in  = '0;
      end else if (run_ff) begin
         if (sts.done) begin
            run_in = 1'b0;
         end else begin
            lfsr_in = lfsr_next;
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      lfsr_ff <= lfsr_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ----- src/maximal_lfsr_polynomial_test.sv -----
// Top level of the maximal-length Galois LFSR polynomial test.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata: candidate_poly[23:0]
//   rsp     | out | rsp_tvalid/tready    | tdata: tested_poly, weight_match,
//           |     |                      |        cycle_period, is_maximal
//   csr     | in  | csr_we (no wait)     | csr_index, csr_wdata
//
// One item at a time: the item is accepted, its ones are counted, then the engine
// checks and steps the LFSR once per cycle until the seed comes back or the step
// index reaches 2^width - 1; it does not run on a weight mismatch. The result then
// goes to the output register once that register is free.
// The output register lets the next item in while a result waits on rsp_tready.
// Synchronous active-high reset; config resets to width 24, weight 4, seed 7.
module maximal_lfsr_polynomial_test
   import mlfsr_pkg::*;
#(
   parameter int MAX_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [23:0] candidate_poly
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // [23:0] tested_poly, [24] weight_match,
                                             // [48:25] cycle_period, [49] is_maximal
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   // config registers
   logic [CFG_W-1:0]  cfg_width_ff,  cfg_width_in;
   logic [CFG_W-1:0]  cfg_weight_ff, cfg_weight_in;
   logic [DATA_W-1:0] cfg_seed_ff,   cfg_seed_in;

   // sequencer
   fsm_state_type state_ff, state_in;

   // per-item working registers
   logic [DATA_W-1:0]    poly_ff,       poly_in;
   logic [CFG_W-1:0]     wid_ff,        wid_in;
   logic [MAX_WIDTH-1:0] limit_ff,      limit_in;
   logic                 res_match_ff,  res_match_in;
   logic [MAX_WIDTH-1:0] res_period_ff, res_period_in;
   logic                 res_max_ff,    res_max_in;

   // output register
   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [DATA_W-1:0]    rsp_poly_ff,   rsp_poly_in;
   logic                 rsp_match_ff,  rsp_match_in;
   logic [DATA_W-1:0]    rsp_period_ff, rsp_period_in;
   logic                 rsp_max_ff,    rsp_max_in;

   logic [CFG_W-1:0]     wid_clamp;
   logic [DATA_W-1:0]    pop_mask;
   logic [CFG_W-1:0]     ones;
   logic                 eng_start;
   eng_sts_type          eng_sts;
   logic [MAX_WIDTH-1:0] eng_steps;
   logic                 req_fire;
   logic                 out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_max_ff, rsp_period_ff, rsp_match_ff, rsp_poly_ff};

   // width above the bound runs as the bound
   always_comb begin
      wid_clamp = cfg_width_ff;
      if (int'(cfg_width_ff) > MAX_WIDTH) begin
         wid_clamp = CFG_W'(MAX_WIDTH);
      end
   end

   // last step index: 2^width - 1
   always_comb begin
      for (int b = 0; b < MAX_WIDTH; b++) begin
         limit_in[b] = (b < int'(wid_clamp));
      end
   end

   // ones are counted over bits 0..width inclusive
   always_comb begin
      for (int b = 0; b < DATA_W; b++) begin
         pop_mask[b] = (b <= int'(wid_ff));
      end
   end

   assign ones      = CFG_W'($countones(poly_ff & pop_mask));
   assign eng_start = (state_ff == ST_COUNT) && (ones == cfg_weight_ff);

   mlfsr_engine #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .start (eng_start),
      .poly  (poly_ff),
      .seed  (cfg_seed_ff),
      .limit (limit_ff),
      .sts   (eng_sts),
      .steps (eng_steps)
   );

   // register writes
   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_weight_in = cfg_weight_ff;
      cfg_seed_in   = cfg_seed_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:  cfg_width_in  = csr_wdata[CFG_W-1:0];
            REG_WEIGHT: cfg_weight_in = csr_wdata[CFG_W-1:0];
            REG_SEED:   cfg_seed_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      poly_in       = poly_ff;
      wid_in        = wid_ff;
      res_match_in  = res_match_ff;
      res_period_in = res_period_ff;
      res_max_in    = res_max_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_poly_in   = rsp_poly_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_period_in = rsp_period_ff;
      rsp_max_in    = rsp_max_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               poly_in  = req_tdata;
               wid_in   = wid_clamp;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            res_match_in = eng_start;
            if (eng_start) begin
               state_in = ST_RUN;
            end else begin
               res_period_in = '0;
               res_max_in    = 1'b0;
               state_in      = ST_DONE;
            end
         end
         ST_RUN: begin
            if (eng_sts.done) begin
               res_period_in = eng_sts.found ? eng_steps : '0;
               res_max_in    = eng_sts.found && (eng_steps == limit_ff);
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_poly_in   = poly_ff;
               rsp_match_in  = res_match_ff;
               rsp_period_in = DATA_W'(res_period_ff);
               rsp_max_in    = res_max_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cfg_width_ff  <= WIDTH_RST;
         cfg_weight_ff <= WEIGHT_RST;
         cfg_seed_ff   <= SEED_RST;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_weight_ff <= cfg_weight_in;
         cfg_seed_ff   <= cfg_seed_in;
      end
   end

   always_ff @(posedge clock) begin
      poly_ff       <= poly_in;
      wid_ff        <= wid_in;
      if (req_fire) begin
         limit_ff <= limit_in;
      end
      res_match_ff  <= res_match_in;
      res_period_ff <= res_period_in;
      res_max_ff    <= res_max_in;
      rsp_poly_ff   <= rsp_poly_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_period_ff <= rsp_period_in;
      rsp_max_ff    <= rsp_max_in;
   end

`ifndef SYNTH
   // engine only finishes while the sequencer waits on it
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      eng_sts.done |-> (state_ff == ST_RUN))
      else $error("engine done outside run");

   // an accepted item goes straight to counting
   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_COUNT))
      else $error("accepted item not counted");

   // maximal result needs a weight match
   a_max_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_max_ff || rsp_match_ff))
      else $error("maximal without weight match");

   // a nonzero period only comes from a matched candidate
   a_period_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_period_ff == '0) || rsp_match_ff))
      else $error("period without weight match");
`endif

endmodule
